FILE: rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and codes for the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int KEY_W = 32;
	localparam int ID_W  = 20;
	localparam int CNT_W = 11;
	localparam int ENT_W = KEY_W + ID_W;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_PEEK   = 2'd2,
		OP_FIND   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,  // capture root, pick the path for the latched request
		S_UP_RD,     // read parent of current position
		S_UP_CMP,    // compare parent with carried entry
		S_DN_LAST,   // load last entry as the carried entry
		S_DN_RDL,    // read left child
		S_DN_RDR,    // read right child
		S_DN_CMP,    // choose smallest, move child up or finish
		S_FIND_RD,
		S_FIND_CMP,
		S_RESULT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     start;      // latch request, read root
		logic     root_cap;   // capture root read data
		logic     last_rd;    // read last entry
		logic     dn_load;    // carried entry <= read data
		logic     up_rd;      // read parent
		logic     up_swap;    // parent moves down, pos <= parent
		logic     up_place;   // write carried entry at pos
		logic     dn_rdl;     // read left child
		logic     dn_rdr;     // read right child
		logic     dn_capl;    // capture left read data
		logic     dn_swap;    // best child moves up, pos <= best
		logic     dn_place;   // write carried entry at pos
		logic     find_rd;    // read scan index
		logic     find_hit;   // record scan hit
		logic     find_next;  // advance scan index
		logic     out_load;   // load output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		op_t  op;
		logic rejected;      // full insert or empty delete/peek
		logic pos_root;      // pos == 0
		logic parent_gt;     // stored parent key > carried key
		logic has_left;
		logic child_lt;      // best child key < carried key
		logic id_match;
		logic scan_done;
	} stat_t;

endpackage

FILE: rtl/bmhq_datapath.sv
// ----------------------------------------------------------------------------
// bmhq_datapath
// Heap memory, position and count registers, comparators, result register.
// ----------------------------------------------------------------------------
module bmhq_datapath import bmhq_pkg::*; #(
	parameter int CAPACITY = 1024,
	parameter int AW       = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [1:0]        operation,
	input  logic [KEY_W-1:0]  key,
	input  logic [ID_W-1:0]   node_id,
	output logic [1:0]        status,
	output logic [KEY_W-1:0]  key_out,
	output logic [ID_W-1:0]   node_out,
	output logic [CNT_W-1:0]  count
);

	localparam logic [AW:0] CAP = (AW+1)'(CAPACITY);

	logic [ENT_W-1:0] mem [CAPACITY];
	logic [ENT_W-1:0] rd_q;
	logic [ENT_W-1:0] left_q;
	logic [ENT_W-1:0] cur_q;      // entry being sifted
	logic [ENT_W-1:0] root_q;
	logic [AW:0]      cnt_q;
	logic [AW:0]      pos_q;
	logic [AW:0]      scan_q;
	op_t              op_q;
	logic [ID_W-1:0]  id_q;
	logic [1:0]       st_q;
	logic [ENT_W-1:0] res_q;

	logic [AW:0]      parent;
	logic [AW+1:0]    left_ix;
	logic [AW+1:0]    right_ix;
	logic             has_right;
	logic             right_best;
	logic [ENT_W-1:0] best_ent;
	logic [AW:0]      best_ix;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [ENT_W-1:0] wr_data;
	logic [AW-1:0]    rd_addr;
	logic             rd_en;

	assign parent    = (pos_q - (AW+1)'(1)) >> 1;
	assign left_ix   = {pos_q, 1'b1};
	assign right_ix  = left_ix + (AW+2)'(1);
	assign has_right = right_ix < {1'b0, cnt_q};

	// tie between children goes left: right wins only when strictly smaller
	assign right_best = has_right &&
		(rd_q[ENT_W-1:ID_W] < left_q[ENT_W-1:ID_W]);
	assign best_ent = right_best ? rd_q : left_q;
	assign best_ix  = right_best ? right_ix[AW:0] : left_ix[AW:0];

	always_comb begin
		stat.op        = op_q;
		stat.rejected  = (st_q == ST_FULL) || (st_q == ST_EMPTY);
		stat.pos_root  = (pos_q == '0);
		stat.parent_gt = rd_q[ENT_W-1:ID_W] > cur_q[ENT_W-1:ID_W];
		stat.has_left  = left_ix < {1'b0, cnt_q};
		stat.child_lt  = best_ent[ENT_W-1:ID_W] < cur_q[ENT_W-1:ID_W];
		stat.id_match  = rd_q[ID_W-1:0] == id_q;
		stat.scan_done = scan_q >= cnt_q;
	end

	always_comb begin
		rd_en   = cmd.start | cmd.last_rd | cmd.up_rd | cmd.dn_rdl | cmd.dn_rdr |
			cmd.find_rd;
		rd_addr = '0;      // start reads the root
		if (cmd.last_rd) begin
			// count already dropped by one, so it indexes the last entry
			rd_addr = cnt_q[AW-1:0];
		end else if (cmd.up_rd) begin
			rd_addr = parent[AW-1:0];
		end else if (cmd.dn_rdl) begin
			rd_addr = left_ix[AW-1:0];
		end else if (cmd.dn_rdr) begin
			rd_addr = right_ix[AW-1:0];
		end else if (cmd.find_rd) begin
			rd_addr = scan_q[AW-1:0];
		end
		wr_en   = cmd.up_swap | cmd.up_place | cmd.dn_swap | cmd.dn_place;
		wr_addr = pos_q[AW-1:0];
		wr_data = cur_q;
		if (cmd.up_swap) begin
			wr_data = rd_q;
		end else if (cmd.dn_swap) begin
			wr_data = best_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			id_q  <= node_id;
			cur_q <= {key, node_id};
		end
		if (cmd.dn_load) begin
			cur_q <= rd_q;
		end
		if (cmd.root_cap) begin
			root_q <= rd_q;
		end
		if (cmd.dn_capl) begin
			left_q <= rd_q;
		end
		if (cmd.find_hit) begin
			res_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pos_q  <= '0;
			scan_q <= '0;
			op_q   <= OP_INSERT;
			st_q   <= ST_OK;
		end else begin
			if (cmd.start) begin
				op_q   <= op_t'(operation);
				scan_q <= '0;
				st_q   <= ST_OK;
				case (op_t'(operation))
					OP_INSERT: begin
						if (cnt_q >= CAP) begin
							st_q <= ST_FULL;
						end else begin
							pos_q <= cnt_q;
							cnt_q <= cnt_q + (AW+1)'(1);
						end
					end
					OP_DELETE: begin
						if (cnt_q == '0) begin
							st_q <= ST_EMPTY;
						end else begin
							pos_q <= '0;
							cnt_q <= cnt_q - (AW+1)'(1);
						end
					end
					OP_PEEK: begin
						if (cnt_q == '0) begin
							st_q <= ST_EMPTY;
						end
					end
					OP_FIND: begin
						st_q <= ST_NOTFOUND;
					end
					default: begin
					end
				endcase
			end
			if (cmd.up_swap) begin
				pos_q <= parent;
			end
			if (cmd.dn_swap) begin
				pos_q <= best_ix;
			end
			if (cmd.find_hit) begin
				st_q <= ST_OK;
			end
			if (cmd.find_next) begin
				scan_q <= scan_q + (AW+1)'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status <= st_q;
			count  <= CNT_W'(cnt_q);
			key_out  <= '0;
			node_out <= '0;
			if (st_q == ST_OK) begin
				if (op_q == OP_DELETE || op_q == OP_PEEK) begin
					key_out  <= root_q[ENT_W-1:ID_W];
					node_out <= root_q[ID_W-1:0];
				end else if (op_q == OP_FIND) begin
					key_out  <= res_q[ENT_W-1:ID_W];
					node_out <= res_q[ID_W-1:0];
				end
			end
		end
	end

endmodule

FILE: rtl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for sift up, sift down and linear find.
// ----------------------------------------------------------------------------
module bmhq_ctrl import bmhq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   ov_q;
	logic   res_free;

	// result register free: empty, or its item leaves this cycle
	assign res_free = !ov_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.op)
					OP_INSERT: state_d = stat.rejected ? S_RESULT : S_UP_RD;
					OP_DELETE: state_d = stat.rejected ? S_RESULT : S_DN_LAST;
					OP_FIND:   state_d = S_FIND_RD;
					default:   state_d = S_RESULT;
				endcase
			end
			S_UP_RD: begin
				state_d = stat.pos_root ? S_RESULT : S_UP_CMP;
			end
			S_UP_CMP: begin
				state_d = stat.parent_gt ? S_UP_RD : S_RESULT;
			end
			S_DN_LAST: begin
				state_d = S_DN_RDL;
			end
			S_DN_RDL: begin
				state_d = stat.has_left ? S_DN_RDR : S_RESULT;
			end
			S_DN_RDR: begin
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				state_d = stat.child_lt ? S_DN_RDL : S_RESULT;
			end
			S_FIND_RD: begin
				state_d = stat.scan_done ? S_RESULT : S_FIND_CMP;
			end
			S_FIND_CMP: begin
				state_d = stat.id_match ? S_RESULT : S_FIND_RD;
			end
			S_RESULT: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.start = in_valid;
			end
			S_DISPATCH: begin
				cmd.root_cap = 1'b1;
				cmd.last_rd  = (stat.op == OP_DELETE);
			end
			S_UP_RD: begin
				cmd.up_place = stat.pos_root;
				cmd.up_rd    = !stat.pos_root;
			end
			S_UP_CMP: begin
				cmd.up_swap  = stat.parent_gt;
				cmd.up_place = !stat.parent_gt;
			end
			S_DN_LAST: begin
				cmd.dn_load = 1'b1;
			end
			S_DN_RDL: begin
				cmd.dn_rdl   = stat.has_left;
				cmd.dn_place = !stat.has_left;
			end
			S_DN_RDR: begin
				cmd.dn_capl = 1'b1;
				cmd.dn_rdr  = 1'b1;
			end
			S_DN_CMP: begin
				cmd.dn_swap  = stat.child_lt;
				cmd.dn_place = !stat.child_lt;
			end
			S_FIND_RD: begin
				cmd.find_rd = !stat.scan_done;
			end
			S_FIND_CMP: begin
				cmd.find_hit  = stat.id_match;
				cmd.find_next = !stat.id_match;
			end
			S_RESULT: begin
				cmd.out_load = res_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;

`ifndef ASSERT_OFF
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> ov_q) else $error("stalled result dropped");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> res_free) else $error("result overwritten while stalled");
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (state_q == S_IDLE)) else $error("start while busy");
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.up_swap, cmd.up_place, cmd.dn_swap, cmd.dn_place}))
		else $error("two heap writes at once");
`endif

endmodule

FILE: rtl/binary_min_heap_queue_top.sv
// Flow: peek and rejected requests go from dispatch straight to the result state; insert
//   climbs one level per parent read and compare, delete sinks one level per left
//   read, right read and compare, and find reads and compares one entry at a time.
// Throughput: one item in flight; the next is taken in the cycle after the result is
//   loaded, and a stalled earlier result holds back that load. Reset clears the count.
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Array-based binary min-heap priority queue with insert, delete, peek, find.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top import bmhq_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [KEY_W-1:0]  key,
	input  logic [ID_W-1:0]   node_id,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [KEY_W-1:0]  key_out,
	output logic [ID_W-1:0]   node_out,
	output logic [CNT_W-1:0]  count
);

	localparam int AW = $clog2(CAPACITY);

	cmd_t  cmd;
	stat_t stat;

	// controller: sequence each item through the datapath
	bmhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: heap memory, counters and result register
	bmhq_datapath #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.operation (operation),
		.key       (key),
		.node_id   (node_id),
		.status    (status),
		.key_out   (key_out),
		.node_out  (node_out),
		.count     (count)
	);

endmodule

FILE: dv/binary_min_heap_queue_checker.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_checker
// Watches both channels, keeps a shadow heap and compares every result item.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_checker import bmhq_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [KEY_W-1:0]  key,
	input  logic [ID_W-1:0]   node_id,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        status,
	input  logic [KEY_W-1:0]  key_out,
	input  logic [ID_W-1:0]   node_out,
	input  logic [CNT_W-1:0]  count,
	output int                fail_cnt,
	output int                pending,
	output int                done_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t          st;
		logic [KEY_W-1:0] k;
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] n;
	} answer_t;

	logic [KEY_W-1:0] shadow_key [CAPACITY];
	logic [ID_W-1:0]  shadow_id  [CAPACITY];
	int               shadow_n;
	answer_t          answers [$];

	function automatic void swap_at(int a, int b);
		logic [KEY_W-1:0] tk;
		logic [ID_W-1:0]  ti;
		tk = shadow_key[a]; ti = shadow_id[a];
		shadow_key[a] = shadow_key[b]; shadow_id[a] = shadow_id[b];
		shadow_key[b] = tk; shadow_id[b] = ti;
	endfunction

	// Apply one request to the shadow heap and return what the block must say.
	function automatic answer_t heap_apply(op_t op, logic [KEY_W-1:0] k, logic [ID_W-1:0] id);
		answer_t a;
		int      p, l, r, best;
		a = '{ST_OK, '0, '0, '0};
		case (op)
			OP_INSERT: begin
				if (shadow_n >= CAPACITY) begin
					a.st = ST_FULL;
				end else begin
					p = shadow_n;
					shadow_key[p] = k; shadow_id[p] = id;
					shadow_n++;
					while (p > 0 && shadow_key[(p-1)/2] > shadow_key[p]) begin
						swap_at(p, (p-1)/2);
						p = (p-1)/2;
					end
				end
			end
			OP_DELETE, OP_PEEK: begin
				if (shadow_n == 0) begin
					a.st = ST_EMPTY;
				end else begin
					a.k = shadow_key[0]; a.id = shadow_id[0];
					if (op == OP_DELETE) begin
						shadow_n--;
						shadow_key[0] = shadow_key[shadow_n];
						shadow_id[0] = shadow_id[shadow_n];
						p = 0;
						forever begin
							l = 2*p + 1; r = l + 1; best = p;
							if (l >= shadow_n) break;
							if (shadow_key[p] > shadow_key[l]) best = l;
							if (r < shadow_n && shadow_key[best] > shadow_key[r]) best = r;
							if (best == p) break;
							swap_at(p, best);
							p = best;
						end
					end
				end
			end
			default: begin
				a.st = ST_NOTFOUND;
				for (int i = 0; i < shadow_n; i++) begin
					if (shadow_id[i] == id) begin
						a.st = ST_OK; a.k = shadow_key[i]; a.id = id;
						break;
					end
				end
			end
		endcase
		a.n = shadow_n[CNT_W-1:0];
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		if (!arst_n) begin
			shadow_n = 0;
			answers.delete();
			fail_cnt <= 0;
			done_cnt <= 0;
			pending  <= 0;
		end else begin
			if (in_valid && !in_stall)
				answers = {answers, heap_apply(op_t'(operation), key, node_id)};
			if (out_valid && !out_stall) begin
				done_cnt <= done_cnt + 1;
				if (answers.size() == 0) begin
					$error("result item with nothing expected");
					fail_cnt <= fail_cnt + 1;
				end else begin
					a = answers.pop_front();
					if (status !== a.st || key_out !== a.k || node_out !== a.id
							|| count !== a.n) begin
						if (status !== a.st)
							$error("status: expected %0d, got %0d", a.st, status);
						if (key_out !== a.k)
							$error("key_out: expected %h, got %h", a.k, key_out);
						if (node_out !== a.id)
							$error("node_out: expected %h, got %h", a.id, node_out);
						if (count !== a.n)
							$error("count: expected %0d, got %0d", a.n, count);
						fail_cnt <= fail_cnt + 1;
					end
				end
			end
			pending <= answers.size();
		end
	end
endmodule

FILE: dv/binary_min_heap_queue_top_tb.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top_tb
// Drives directed and random heap requests with bursty input and a stalling
// receiver; the checker predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top_tb;
	import bmhq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY  = 1024;
	localparam int N_RANDOM  = 850;
	// Idle-cycle limit: a full-heap find scan plus the receiver's longest stall,
	// taken several times over.
	localparam int IDLE_LIMIT = 20000;

	logic              clk, arst_n;
	logic              in_valid, in_stall;
	logic [1:0]        operation;
	logic [KEY_W-1:0]  key;
	logic [ID_W-1:0]   node_id;
	logic              out_valid, out_stall;
	logic [1:0]        status;
	logic [KEY_W-1:0]  key_out;
	logic [ID_W-1:0]   node_out;
	logic [CNT_W-1:0]  count;
	int                fail_cnt, pending, done_cnt;
	int                idle_cycles;
	int                n_sent, n_deep;
	logic [ID_W-1:0]   recent_ids [$];

	binary_min_heap_queue_top #(.CAPACITY(CAPACITY)) dut (.*);

	binary_min_heap_queue_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Receiver: stall on its own pattern, switching mode now and then so that
	// some stretches never stall.
	int stall_mode;
	initial begin
		out_stall = 0;
		stall_mode = 0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: out_stall <= 0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// Watchdog: count cycles with no handshake on either side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Burst state for the sender; a gap may be inserted before a burst starts.
	int burst_left;

	// Hold one item on the bus until it is taken, then drop valid only if a
	// gap follows.
	task automatic send_item(op_t op, logic [KEY_W-1:0] k, logic [ID_W-1:0] id);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1;
		operation <= op;
		key       <= k;
		node_id   <= id;
		do @(posedge clk); while (in_stall);
		n_sent++;
		if (op == OP_INSERT) begin
			recent_ids = {recent_ids, id};
			if (recent_ids.size() > 64) void'(recent_ids.pop_front());
		end
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 15);            // many ties
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ID_W-1:0] find_id();
		if (recent_ids.size() > 0 && $urandom_range(0, 2) != 0)
			return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
		return ID_W'($urandom);
	endfunction

	initial begin
		op_t op;
		int  level;
		arst_n = 0;
		in_valid = 0; operation = OP_INSERT; key = '0; node_id = '0;
		burst_left = 0;
		n_sent = 0; n_deep = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty-heap cases first.
		send_item(OP_PEEK, '0, '0);
		send_item(OP_DELETE, '0, '0);
		send_item(OP_FIND, '0, '0);
		// Key and id extremes, ties, and a left/right child tie.
		send_item(OP_INSERT, 32'hFFFF_FFFF, 20'hFFFFF);
		send_item(OP_INSERT, 32'h0000_0000, 20'h00000);
		send_item(OP_INSERT, 32'd5, 20'h12345);
		send_item(OP_INSERT, 32'd5, 20'h54321);
		send_item(OP_INSERT, 32'd5, 20'hAAAAA);
		send_item(OP_INSERT, 32'd0, 20'h55555);
		send_item(OP_PEEK, '0, '0);
		send_item(OP_FIND, '0, 20'hFFFFF);
		send_item(OP_FIND, '0, 20'h54321);
		send_item(OP_FIND, '0, 20'h77777);
		send_item(OP_DELETE, '0, '0);
		send_item(OP_DELETE, '0, '0);
		send_item(OP_DELETE, '0, '0);
		send_item(OP_DELETE, '0, '0);
		send_item(OP_DELETE, '0, '0);
		send_item(OP_DELETE, '0, '0);
		send_item(OP_DELETE, '0, '0);   // empty again

		// Fill to capacity once, probe a full-heap insert and a deep find; the
		// random phase then starts from the full heap.
		for (int i = 0; i < CAPACITY; i++)
			send_item(OP_INSERT, rand_key(), ID_W'(i));
		send_item(OP_INSERT, 32'd1, 20'h00001);
		send_item(OP_FIND, '0, ID_W'(CAPACITY - 1));
		send_item(OP_FIND, '0, 20'hFFFFE);

		// Random: phases that lean to inserts or to deletes, picked anew every 200 items.
		level = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 200 == 0) level = $urandom_range(0, 2);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: op = (level == 2) ? OP_DELETE : OP_INSERT;
				4, 5:       op = (level == 0) ? OP_INSERT : OP_DELETE;
				6, 7:       op = OP_DELETE;
				8:          op = OP_PEEK;
				default:    op = OP_FIND;
			endcase
			send_item(op, rand_key(), (op == OP_FIND) ? find_id() : ID_W'($urandom));
			if (op == OP_DELETE) n_deep++;
		end
		in_valid <= 0;

		while (done_cnt < n_sent) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d items (%0d random deletes), checked %0d results;",
			n_sent, n_deep, done_cnt);
		$display("covered empty, full, tied keys, find hits and misses.");
		if (fail_cnt == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
